// ----- rtl/srpg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpg_pkg
// Shared constants, types and the arctangent table of the sphere point generator.
// ----------------------------------------------------------------------------
package srpg_pkg;

  localparam int MAX_DIVISIONS = 256;
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STEPS  = 24;
  localparam int STG_W         = $clog2(CORDIC_STEPS);
  localparam int CW            = 34;
  localparam int QW            = 31;
  localparam int FIELD_W       = 18;
  localparam int D_W           = 9;
  localparam int S_W           = 15;
  localparam int RAD_W         = S_W + 1;
  localparam int RC_W          = $clog2(MAX_DIVISIONS / 2) + 1;
  localparam int PC_W          = $clog2(2 * MAX_DIVISIONS) + 1;
  localparam int DIV_DW        = $clog2(2 * MAX_DIVISIONS) + 1;
  localparam int DIV_NW        = ANGLE_BITS + DIV_DW;
  localparam int CNT_W         = $clog2(DIV_NW + 1);
  localparam int PROD_W        = FIELD_W + QW;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DAT_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DIVISION_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SPHERE_SIZE    = CFG_IDX_W'(1);

  localparam logic [D_W-1:0] DIV_COUNT_RESET = D_W'(20);
  localparam logic [S_W-1:0] SIZE_RESET      = S_W'(256);

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
  localparam logic [QW-1:0]        Q30_ONE     = QW'(1) << 30;

  typedef struct packed {
    logic                 vld;
    logic                 tag;
    logic [1:0]           quad;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } crd_t;

  function automatic logic [31:0] atan_turn(input logic [STG_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004757;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679839;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/srpg_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpg_in_if
// Request channel: one item asks for the next point or a restart.
// ----------------------------------------------------------------------------
interface srpg_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// ----- rtl/srpg_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpg_out_if
// Result channel: one point of the sphere per item.
// ----------------------------------------------------------------------------
interface srpg_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [srpg_pkg::FIELD_W-1:0]   coord_x;
  logic signed [srpg_pkg::FIELD_W-1:0]   coord_y;
  logic signed [srpg_pkg::FIELD_W-1:0]   coord_z;
  logic                                  last_point;
  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  output last_point, input ready);
  modport sink (input valid, input coord_x, input coord_y, input coord_z,
                input last_point, output ready);
endinterface

// ----- rtl/srpg_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpg_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface srpg_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [srpg_pkg::CFG_IDX_W-1:0]   index;
  logic [srpg_pkg::CFG_DAT_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/sphere_ring_point_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_ring_point_generator
// Latitude-ring sphere point generator, one point per request item.
// ----------------------------------------------------------------------------
// Works on one request at a time. A request passes the serial divider, which
// forms the ring and point angles one after the other at one quotient bit per
// cycle (the ring division is skipped with a single ring), then the 24-cell
// rotation chain that both angles pass, then six steps on the shared
// multiplier, and last the output register. The next request can be taken in
// the cycle after the point is loaded into the output register, while it
// still waits to be read.
module sphere_ring_point_generator (
  input  logic        clk,
  input  logic        rst_n,
  srpg_in_if.sink     in_ch,
  srpg_out_if.source  out_ch,
  srpg_cfg_if.sink    cfg_ch
);
  typedef enum logic [3:0] {
    ST_IDLE, ST_DR_GO, ST_DR_WAIT, ST_DP_GO, ST_DP_WAIT,
    ST_CR_RING, ST_CR_PT, ST_CR_WAIT,
    ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_MUL5, ST_DONE
  } state_t;

  localparam int AB = srpg_pkg::ANGLE_BITS;
  localparam int FW = srpg_pkg::FIELD_W;
  localparam int QW = srpg_pkg::QW;
  localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);
  localparam logic [QW-1:0] Q30_ONE_W = srpg_pkg::Q30_ONE;

  state_t                        state_r;
  logic [srpg_pkg::D_W-1:0]      dcount_r;
  logic [srpg_pkg::S_W-1:0]      size_r;
  logic [srpg_pkg::RC_W-1:0]     rc_r;
  logic [srpg_pkg::PC_W-1:0]     pc_r;
  logic [srpg_pkg::RC_W-1:0]     rcw_r;
  logic [srpg_pkg::PC_W-1:0]     pcw_r;
  logic [srpg_pkg::RC_W-1:0]     rings_r;
  logic [srpg_pkg::D_W-1:0]      dw_r;
  logic [srpg_pkg::RAD_W-1:0]    radius_r;
  logic                          last_r;
  logic [AB-1:0]                 rcode_r;
  logic [AB-1:0]                 pcode_r;
  logic [QW-1:0]                 r_sm_r, r_cm_r, p_sm_r, p_cm_r;
  logic                          r_sn_r, r_cn_r, p_sn_r, p_cn_r;
  logic [srpg_pkg::PROD_W-1:0]   prod_r;
  logic [FW-1:0]                 height_r;
  logic [FW-1:0]                 rrad_r;
  logic [FW-1:0]                 x_r;
  logic [FW-1:0]                 z_r;
  logic                          out_valid_r;
  logic [FW-1:0]                 ox_r, oy_r, oz_r;
  logic                          olast_r;
  logic                          out_load;

  logic [srpg_pkg::D_W-1:0]      d_c;
  logic [srpg_pkg::RC_W-1:0]     rings_c;
  logic [srpg_pkg::PC_W-1:0]     pts_c;
  logic [srpg_pkg::RC_W-1:0]     rc0, rc1;
  logic [srpg_pkg::PC_W-1:0]     pc0, pc1;
  logic [srpg_pkg::PC_W:0]       pc_inc;
  logic [srpg_pkg::RC_W:0]       rc_inc;

  logic                          div_start;
  logic [srpg_pkg::DIV_NW-1:0]   div_num;
  logic [srpg_pkg::DIV_DW-1:0]   div_den;
  logic                          div_done;
  logic [srpg_pkg::DIV_NW-1:0]   div_quo;

  srpg_pkg::crd_t                chain [0:srpg_pkg::CORDIC_STEPS];
  srpg_pkg::crd_t                cend;
  logic [QW-1:0]                 s_cl, c_cl, sm_c, cm_c;
  logic                          sn_c, cn_c;

  logic [FW-1:0]                 mul_a;
  logic [QW-1:0]                 mul_b;
  logic [srpg_pkg::PROD_W:0]     rnd;
  logic [FW:0]                   mag;
  logic [FW-1:0]                 fld_pos;
  logic                          in_fire;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_load     = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // sweep position for this request
  always_comb begin
    if (dcount_r < srpg_pkg::D_W'(2)) begin
      d_c = srpg_pkg::D_W'(2);
    end else if (dcount_r > srpg_pkg::D_W'(srpg_pkg::MAX_DIVISIONS)) begin
      d_c = srpg_pkg::D_W'(srpg_pkg::MAX_DIVISIONS);
    end else begin
      d_c = dcount_r;
    end
    rings_c = srpg_pkg::RC_W'(d_c >> 1);
    pts_c   = srpg_pkg::PC_W'({d_c, 1'b0});
    rc0     = in_ch.restart ? '0 : rc_r;
    pc0     = in_ch.restart ? '0 : pc_r;
    rc1     = (rc0 >= rings_c) ? '0 : rc0;
    pc1     = (pc0 >= pts_c) ? '0 : pc0;
    pc_inc  = {1'b0, pc1} + 1'b1;
    rc_inc  = {1'b0, rc1} + 1'b1;
  end

  always_comb begin
    div_start = (state_r == ST_DR_GO) || (state_r == ST_DP_GO);
    if (state_r == ST_DR_GO) begin
      div_num = (srpg_pkg::DIV_NW'(rcw_r) << (AB - 1))
              + srpg_pkg::DIV_NW'((rings_r - 1'b1) >> 1);
      div_den = srpg_pkg::DIV_DW'(rings_r - 1'b1);
    end else begin
      div_num = (srpg_pkg::DIV_NW'(pcw_r) << AB) + srpg_pkg::DIV_NW'(dw_r);
      div_den = srpg_pkg::DIV_DW'({dw_r, 1'b0});
    end
  end

  srpg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    chain[0]      = '0;
    chain[0].vld  = (state_r == ST_CR_RING) || (state_r == ST_CR_PT);
    chain[0].tag  = (state_r == ST_CR_PT);
    chain[0].x    = srpg_pkg::CORDIC_GAIN;
    chain[0].y    = '0;
    if (state_r == ST_CR_PT) begin
      chain[0].quad = pcode_r[AB-1:AB-2];
      chain[0].z    = signed'(srpg_pkg::CW'({pcode_r[AB-3:0], (32 - AB)'(0)}));
    end else begin
      chain[0].quad = rcode_r[AB-1:AB-2];
      chain[0].z    = signed'(srpg_pkg::CW'({rcode_r[AB-3:0], (32 - AB)'(0)}));
    end
  end

  for (genvar i = 0; i < srpg_pkg::CORDIC_STEPS; i++) begin : g_cell
    srpg_cordic_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .stage (srpg_pkg::STG_W'(i)),
      .d_in  (chain[i]),
      .d_out (chain[i+1])
    );
  end

  // clamp and quadrant mapping of the chain output
  always_comb begin
    cend = chain[srpg_pkg::CORDIC_STEPS];
    if (cend.y[srpg_pkg::CW-1]) begin
      s_cl = '0;
    end else if (cend.y > signed'(srpg_pkg::CW'(Q30_ONE_W))) begin
      s_cl = srpg_pkg::Q30_ONE;
    end else begin
      s_cl = cend.y[QW-1:0];
    end
    if (cend.x[srpg_pkg::CW-1]) begin
      c_cl = '0;
    end else if (cend.x > signed'(srpg_pkg::CW'(Q30_ONE_W))) begin
      c_cl = srpg_pkg::Q30_ONE;
    end else begin
      c_cl = cend.x[QW-1:0];
    end
    case (cend.quad)
      2'd0:    begin sm_c = s_cl; sn_c = 1'b0; cm_c = c_cl; cn_c = 1'b0; end
      2'd1:    begin sm_c = c_cl; sn_c = 1'b0; cm_c = s_cl; cn_c = 1'b1; end
      2'd2:    begin sm_c = s_cl; sn_c = 1'b1; cm_c = c_cl; cn_c = 1'b1; end
      default: begin sm_c = c_cl; sn_c = 1'b1; cm_c = s_cl; cn_c = 1'b0; end
    endcase
  end

  // shared multiplier operands and rounding of the last product
  always_comb begin
    unique case (state_r)
      ST_MUL0: begin mul_a = FW'(radius_r); mul_b = r_sm_r; end
      ST_MUL1: begin mul_a = FW'(radius_r); mul_b = r_cm_r; end
      ST_MUL3: begin mul_a = rrad_r;        mul_b = p_cm_r; end
      ST_MUL4: begin mul_a = rrad_r;        mul_b = p_sm_r; end
      default: begin mul_a = '0;            mul_b = '0;     end
    endcase
    rnd     = {1'b0, prod_r} + ((srpg_pkg::PROD_W + 1)'(1) << 29);
    mag     = rnd[30 +: FW + 1];
    fld_pos = mag[FW-1:0];
  end

  function automatic logic [FW-1:0] to_field(input logic neg, input logic [FW-1:0] m);
    return neg ? FW'(0) - m : m;
  endfunction

  always_ff @(posedge clk) begin
    prod_r <= srpg_pkg::PROD_W'(mul_a * mul_b);
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dcount_r    <= srpg_pkg::DIV_COUNT_RESET;
      size_r      <= srpg_pkg::SIZE_RESET;
      rc_r        <= '0;
      pc_r        <= '0;
      height_r    <= '0;
      rrad_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          srpg_pkg::REG_DIVISION_COUNT: dcount_r <= cfg_ch.data[srpg_pkg::D_W-1:0];
          srpg_pkg::REG_SPHERE_SIZE:    size_r   <= cfg_ch.data[srpg_pkg::S_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            rcw_r    <= rc1;
            pcw_r    <= pc1;
            rings_r  <= rings_c;
            dw_r     <= d_c;
            radius_r <= {size_r, 1'b0};
            if (pc_inc >= {1'b0, pts_c}) begin
              pc_r <= '0;
              if (rc_inc >= {1'b0, rings_c}) begin
                rc_r   <= '0;
                last_r <= 1'b1;
              end else begin
                rc_r   <= rc_inc[srpg_pkg::RC_W-1:0];
                last_r <= 1'b0;
              end
            end else begin
              pc_r   <= pc_inc[srpg_pkg::PC_W-1:0];
              rc_r   <= rc1;
              last_r <= 1'b0;
            end
            state_r <= (rings_c > srpg_pkg::RC_W'(1)) ? ST_DR_GO : ST_DP_GO;
            if (!(rings_c > srpg_pkg::RC_W'(1))) begin
              rcode_r <= AB'(0) - QUARTER;
            end
          end
        end
        ST_DR_GO:   state_r <= ST_DR_WAIT;
        ST_DR_WAIT: begin
          if (div_done) begin
            rcode_r <= div_quo[AB-1:0] - QUARTER;
            state_r <= ST_DP_GO;
          end
        end
        ST_DP_GO:   state_r <= ST_DP_WAIT;
        ST_DP_WAIT: begin
          if (div_done) begin
            pcode_r <= div_quo[AB-1:0];
            state_r <= ST_CR_RING;
          end
        end
        ST_CR_RING: state_r <= ST_CR_PT;
        ST_CR_PT:   state_r <= ST_CR_WAIT;
        ST_CR_WAIT: begin
          if (cend.vld && !cend.tag) begin
            r_sm_r <= sm_c; r_sn_r <= sn_c; r_cm_r <= cm_c; r_cn_r <= cn_c;
          end
          if (cend.vld && cend.tag) begin
            p_sm_r <= sm_c; p_sn_r <= sn_c; p_cm_r <= cm_c; p_cn_r <= cn_c;
            state_r <= ST_MUL0;
          end
        end
        ST_MUL0: state_r <= ST_MUL1;
        ST_MUL1: begin
          height_r <= to_field(r_sn_r, fld_pos);
          state_r  <= ST_MUL2;
        end
        ST_MUL2: begin
          rrad_r  <= to_field(r_cn_r, fld_pos);
          state_r <= ST_MUL3;
        end
        ST_MUL3: state_r <= ST_MUL4;
        ST_MUL4: begin
          x_r     <= to_field(p_cn_r, fld_pos);
          state_r <= ST_MUL5;
        end
        ST_MUL5: begin
          z_r     <= to_field(p_sn_r, fld_pos);
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            ox_r    <= x_r;
            oy_r    <= height_r;
            oz_r    <= z_r;
            olast_r <= last_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.coord_x    = signed'(ox_r);
  assign out_ch.coord_y    = signed'(oy_r);
  assign out_ch.coord_z    = signed'(oz_r);
  assign out_ch.last_point = olast_r;
endmodule

// ----- rtl/srpg_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srpg_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [srpg_pkg::DIV_NW-1:0]   num,
  input  logic [srpg_pkg::DIV_DW-1:0]   den,
  output logic                          done,
  output logic [srpg_pkg::DIV_NW-1:0]   quo
);
  logic                          busy_r;
  logic                          done_r;
  logic [srpg_pkg::CNT_W-1:0]    cnt_r;
  logic [srpg_pkg::DIV_NW-1:0]   num_r;
  logic [srpg_pkg::DIV_NW-1:0]   quo_r;
  logic [srpg_pkg::DIV_DW-1:0]   den_r;
  logic [srpg_pkg::DIV_DW-1:0]   rem_r;
  logic [srpg_pkg::DIV_DW:0]     trial;
  logic                          qbit;
  logic [srpg_pkg::DIV_DW-1:0]   rem_nxt;

  always_comb begin
    trial   = {rem_r, num_r[srpg_pkg::DIV_NW-1]};
    qbit    = (trial >= {1'b0, den_r});
    rem_nxt = qbit ? srpg_pkg::DIV_DW'(trial - {1'b0, den_r})
                   : trial[srpg_pkg::DIV_DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= srpg_pkg::CNT_W'(srpg_pkg::DIV_NW);
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        quo_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        num_r <= num_r << 1;
        quo_r <= {quo_r[srpg_pkg::DIV_NW-2:0], qbit};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == srpg_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

// ----- rtl/srpg_cordic_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpg_cordic_cell
// One registered rotation step of the sine and cosine chain.
// ----------------------------------------------------------------------------
module srpg_cordic_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [srpg_pkg::STG_W-1:0]  stage,
  input  srpg_pkg::crd_t              d_in,
  output srpg_pkg::crd_t              d_out
);
  srpg_pkg::crd_t                    q_r;
  srpg_pkg::crd_t                    q_nxt;
  logic signed [srpg_pkg::CW-1:0]    xi;
  logic signed [srpg_pkg::CW-1:0]    yi;
  logic signed [srpg_pkg::CW-1:0]    dx;
  logic signed [srpg_pkg::CW-1:0]    dy;
  logic signed [srpg_pkg::CW-1:0]    at;

  always_comb begin
    xi    = d_in.x;
    yi    = d_in.y;
    dx    = yi >>> stage;
    dy    = xi >>> stage;
    at    = signed'(srpg_pkg::CW'(srpg_pkg::atan_turn(stage)));
    q_nxt = d_in;
    if (!d_in.z[srpg_pkg::CW-1]) begin
      q_nxt.x = xi - dx;
      q_nxt.y = yi + dy;
      q_nxt.z = d_in.z - at;
    end else begin
      q_nxt.x = xi + dx;
      q_nxt.y = yi - dy;
      q_nxt.z = d_in.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;
endmodule
